// ===== src/lsc_pkg.sv =====
package lsc_pkg;

   // byte codes with a special meaning in the text stream
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   // severity codes on the response channel
   localparam logic [2:0] SEV_CRITICAL = 3'd0;
   localparam logic [2:0] SEV_ERROR    = 3'd1;
   localparam logic [2:0] SEV_WARNING  = 3'd2;
   localparam logic [2:0] SEV_DEBUG    = 3'd3;
   localparam logic [2:0] SEV_INFO     = 3'd4;

   // keywords, first character in the most significant byte
   localparam logic [63:0] KW_CRITICAL = 64'h637269746963616C;
   localparam logic [39:0] KW_FATAL    = 40'h666174616C;
   localparam logic [39:0] KW_ERROR    = 40'h6572726F72;
   localparam logic [47:0] KW_FAILED   = 48'h6661696C6564;
   localparam logic [55:0] KW_WARNING  = 56'h7761726E696E67;
   localparam logic [31:0] KW_WARN     = 32'h7761726E;
   localparam logic [39:0] KW_DEBUG    = 40'h6465627567;

   // per-line hit flags
   typedef struct packed {
      logic debug;
      logic warning;
      logic error;
      logic critical;
   } found_type;

   // ascii lowercase, letters only
   function automatic logic [7:0] to_lower(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         r = c + CASE_OFFSET;
      end
      return r;
   endfunction

endpackage

// ===== src/lsc_req_if.sv =====
interface lsc_req_if;
   import lsc_pkg::*;

   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== src/lsc_rsp_if.sv =====
interface lsc_rsp_if;
   import lsc_pkg::*;

   logic       valid;
   logic       ready;
   logic [2:0] severity;

   modport source (output valid, output severity, input ready);
   modport sink   (input valid, input severity, output ready);
endinterface

// ===== src/lsc_keyword_match.sv =====
module lsc_keyword_match
   import lsc_pkg::*;
(
   input  logic [63:0] window,
   output found_type   hits
);

   // each keyword must end at the newest byte of the window
   always_comb begin
      hits          = '0;
      hits.critical = (window == KW_CRITICAL) || (window[39:0] == KW_FATAL);
      hits.error    = (window[39:0] == KW_ERROR) || (window[47:0] == KW_FAILED);
      hits.warning  = (window[55:0] == KW_WARNING) || (window[31:0] == KW_WARN);
      hits.debug    = (window[39:0] == KW_DEBUG);
   end

endmodule

// ===== src/log_line_severity_classifier_unit.sv =====
// Log line severity classifier.
// req_bus carries one text byte per request (data_byte); rsp_bus carries one
// severity code (0 critical, 1 error, 2 warning, 3 debug, 4 info) for every
// newline byte, and nothing for any other byte.
// Keywords critical/fatal, error/failed, warning/warn and debug are matched
// case-insensitively; only the first SCAN_LIMIT bytes of a line are scanned
// and a NUL byte stops scanning until the newline.
// A newline accepted into the input register moves on to the result register,
// which shows its severity on rsp_bus until the result handshake.
// Throughput: one request per cycle while req_bus.ready is high; the window
// shift, keyword compares and flag update all sit between the input register
// and the result register. When rsp_bus stalls, the result register holds;
// the input register still drains ordinary bytes, and only a second newline
// waits in it, which then drops req_bus.ready until the held result is taken.
// Synchronous reset empties both registers and clears the line state; a
// partial line is never reported.
module log_line_severity_classifier_unit
   import lsc_pkg::*;
#(
   parameter int SCAN_LIMIT = 255
)
(
   input  logic          clock,
   input  logic          reset,
   lsc_req_if.sink       req_bus,
   lsc_rsp_if.source     rsp_bus
);

   localparam int PosWidth = $clog2(SCAN_LIMIT + 1);
   localparam logic [PosWidth-1:0] PosLimit = PosWidth'(SCAN_LIMIT);

   logic                s1_valid_ff, s1_valid_in;
   logic [7:0]          s1_byte_ff;
   logic [55:0]         recent_ff, recent_in;
   logic [PosWidth-1:0] pos_ff, pos_in;
   logic                stopped_ff, stopped_in;
   found_type           found_ff, found_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          severity_ff, severity_in;

   logic                is_newline;
   logic                out_free;
   logic                s1_fire;
   logic [7:0]          lower_byte;
   logic [63:0]         window;
   found_type           hits;

   // handshake between the two register stages
   assign is_newline    = (s1_byte_ff == CHAR_NEWLINE);
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign s1_fire       = s1_valid_ff && (!is_newline || out_free);
   assign req_bus.ready = !s1_valid_ff || s1_fire;
   assign s1_valid_in   = req_bus.valid || (s1_valid_ff && !s1_fire);

   // candidate window with the new byte
   assign lower_byte = to_lower(s1_byte_ff);
   assign window     = {recent_ff, lower_byte};

   lsc_keyword_match u_match (
      .window (window),
      .hits   (hits)
   );

   // line state update and result generation
   always_comb begin
      recent_in    = recent_ff;
      pos_in       = pos_ff;
      stopped_in   = stopped_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      severity_in  = severity_ff;
      if (s1_fire) begin
         if (is_newline) begin
            rsp_valid_in = 1'b1;
            if (found_ff.critical) begin
               severity_in = SEV_CRITICAL;
            end else if (found_ff.error) begin
               severity_in = SEV_ERROR;
            end else if (found_ff.warning) begin
               severity_in = SEV_WARNING;
            end else if (found_ff.debug) begin
               severity_in = SEV_DEBUG;
            end else begin
               severity_in = SEV_INFO;
            end
            recent_in  = '0;
            pos_in     = '0;
            stopped_in = 1'b0;
            found_in   = '0;
         end else if (!stopped_ff && pos_ff < PosLimit) begin
            if (s1_byte_ff == CHAR_NUL) begin
               stopped_in = 1'b1;
            end else begin
               recent_in = window[55:0];
               pos_in    = pos_ff + PosWidth'(1);
               found_in  = found_ff | hits;
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         recent_ff    <= '0;
         pos_ff       <= '0;
         stopped_ff   <= 1'b0;
         found_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         recent_ff    <= recent_in;
         pos_ff       <= pos_in;
         stopped_ff   <= stopped_in;
         found_ff     <= found_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_bus.ready) begin
         s1_byte_ff <= req_bus.data_byte;
      end
      severity_ff <= severity_in;
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.severity = severity_ff;

endmodule

// ===== src/lsc_checker.sv =====
module lsc_checker
   import lsc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_severity
);

   // only defined severity codes leave the block
   a_sev_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_severity == SEV_CRITICAL || rsp_severity == SEV_ERROR ||
                     rsp_severity == SEV_WARNING || rsp_severity == SEV_DEBUG ||
                     rsp_severity == SEV_INFO))
      else $error("severity code out of range");

   // reset drops any pending response
   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // both stages are empty after reset, so a request can be taken
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("request not ready after reset");

   // stalled response stays
   a_stall_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // stalled response holds its code
   a_stall_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_severity))
      else $error("response changed while stalled");

endmodule

bind log_line_severity_classifier_unit lsc_checker u_lsc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_severity (rsp_bus.severity)
);

// ===== dv/line_severity_monitor.sv =====
`timescale 1ns / 100ps

module line_severity_monitor
   import lsc_pkg::*;
#(
   parameter int SCAN_LIMIT = 255
)
(
   input  logic  clock,
   input  logic  reset,
   lsc_req_if    req_mon,
   lsc_rsp_if    rsp_mon,
   output int    error_count,
   output int    severities_due
);

   // predicted line state
   logic [55:0] line_window;
   int unsigned scanned_count;
   logic        scan_halted;
   found_type   line_hits;

   // severities still owed by the block, oldest first
   logic [2:0]  severity_q[$];

   // true when the low n bytes of the window spell the keyword
   function automatic bit ends_in(input logic [63:0] w, input logic [63:0] word,
                                  input int n);
      logic [63:0] mask;
      mask = (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
      return (w & mask) == word;
   endfunction

   task automatic clear_line();
      line_window   = '0;
      scanned_count = 0;
      scan_halted   = 1'b0;
      line_hits     = '0;
   endtask

   // fold one accepted text byte into the line state
   task automatic absorb_byte(input logic [7:0] b);
      logic [7:0]  c;
      logic [63:0] w;
      if (b == CHAR_NEWLINE) begin
         if (line_hits.critical) begin
            severity_q.push_back(SEV_CRITICAL);
         end else if (line_hits.error) begin
            severity_q.push_back(SEV_ERROR);
         end else if (line_hits.warning) begin
            severity_q.push_back(SEV_WARNING);
         end else if (line_hits.debug) begin
            severity_q.push_back(SEV_DEBUG);
         end else begin
            severity_q.push_back(SEV_INFO);
         end
         clear_line();
      end else if (!scan_halted && scanned_count < SCAN_LIMIT) begin
         if (b == CHAR_NUL) begin
            scan_halted = 1'b1;
         end else begin
            c = b;
            if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
               c = c + CASE_OFFSET;
            end
            w = {line_window, c};
            if (ends_in(w, KW_CRITICAL, 8) || ends_in(w, KW_FATAL, 5)) begin
               line_hits.critical = 1'b1;
            end
            if (ends_in(w, KW_ERROR, 5) || ends_in(w, KW_FAILED, 6)) begin
               line_hits.error = 1'b1;
            end
            if (ends_in(w, KW_WARNING, 7) || ends_in(w, KW_WARN, 4)) begin
               line_hits.warning = 1'b1;
            end
            if (ends_in(w, KW_DEBUG, 5)) begin
               line_hits.debug = 1'b1;
            end
            line_window   = w[55:0];
            scanned_count = scanned_count + 1;
         end
      end
   endtask

   // watch both channels, compare results against the oldest prediction
   always @(posedge clock) begin
      logic [2:0] want;
      if (reset) begin
         clear_line();
         severity_q.delete();
         error_count <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (severity_q.size() == 0) begin
               $display("%0t: unexpected severity %0d, nothing pending",
                        $time, rsp_mon.severity);
               error_count <= error_count + 1;
            end else begin
               want = severity_q.pop_front();
               if (rsp_mon.severity !== want) begin
                  $display("%0t: severity mismatch, expected %0d, actual %0d",
                           $time, want, rsp_mon.severity);
                  error_count <= error_count + 1;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            absorb_byte(req_mon.data_byte);
         end
      end
      severities_due <= severity_q.size();
   end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import lsc_pkg::*;

   localparam int SCAN_LIMIT     = 255;
   localparam int TOTAL_BYTES    = 1045;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 8;

   logic clock;
   logic reset;

   lsc_req_if req_bus();
   lsc_rsp_if rsp_bus();

   int   error_total;
   int   results_due;
   logic hold_now;
   bit   steady;
   int   send_mode;
   int   send_mode_left;
   int   bytes_sent;

   // keywords, their near misses and short pieces of them
   string word_bank [0:13] = '{"critical", "fatal", "error", "failed", "warning",
                               "warn", "debug", "warnin", "erro", "debu", "fata",
                               "critica", "faile", "crit"};
   string letter_pool = "abcdefgilnortuw";

   log_line_severity_classifier_unit #(.SCAN_LIMIT(SCAN_LIMIT)) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   line_severity_monitor #(.SCAN_LIMIT(SCAN_LIMIT)) severity_mon (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .error_count    (error_total),
      .severities_due (results_due)
   );

   // 12 ns clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) begin
         return $urandom_range(1, 3);
      end else if (r < 96) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic string mixed_case(input string s);
      string r;
      r = s;
      for (int i = 0; i < r.len(); i++) begin
         if (r[i] >= "a" && r[i] <= "z" && $urandom_range(0, 1) == 1) begin
            r[i] = r[i] - 8'd32;
         end
      end
      return r;
   endfunction

   function automatic logic [7:0] any_but_newline();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if (b == CHAR_NEWLINE) begin
         b = 8'hFF;
      end
      return b;
   endfunction

   // offer one byte, with an optional gap first, and wait for the request to go through
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = 0;
      if (send_mode_left == 0) begin
         send_mode      = $urandom_range(0, 2);
         send_mode_left = $urandom_range(16, 160);
      end
      send_mode_left = send_mode_left - 1;
      if (!steady && send_mode != 0 && $urandom_range(0, 99) < 30) begin
         gap = idle_length();
      end
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      bytes_sent = bytes_sent + 1;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(s[i]);
      end
   endtask

   task automatic send_letters(input int n);
      repeat (n) begin
         send_text(mixed_case(string'(letter_pool[$urandom_range(0, letter_pool.len() - 1)])));
      end
   endtask

   // one line of random pieces: keywords, near misses, letters, noise
   task automatic send_random_line();
      int pieces;
      int pick;
      if ($urandom_range(0, 99) < 2) begin
         send_letters($urandom_range(240, 300));
      end
      pieces = $urandom_range(0, 5);
      repeat (pieces) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            send_text(mixed_case(word_bank[$urandom_range(0, 13)]));
         end else if (pick < 60) begin
            send_letters($urandom_range(1, 4));
         end else if (pick < 72) begin
            send_byte(8'($urandom_range(8'h20, 8'h7E)));
         end else if (pick < 86) begin
            send_byte(any_but_newline());
         end else if (pick < 90) begin
            send_byte(CHAR_NUL);
         end else if (pick < 95) begin
            send_byte(8'h0D);
         end else begin
            send_byte(" ");
         end
      end
      send_byte(CHAR_NEWLINE);
   endtask

   // stimulus and verdict
   initial begin
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.data_byte <= 8'h00;
      hold_now          <= 1'b0;
      steady         = 1'b0;
      send_mode      = 0;
      send_mode_left = 0;
      bytes_sent     = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed lines: each keyword, priority, empty, cr, nul, high bytes
      send_byte(CHAR_NEWLINE);
      send_text("CRITICAL\n");
      send_text("Fatal\n");
      send_text("eRRor\n");
      send_text("failed\n");
      send_text("WARNING\r\n");
      send_text("warn\n");
      send_text("[DEBUG]\n");
      send_text("debug warn error fatal\n");
      send_byte("x");
      send_byte(CHAR_NUL);
      send_text("error\n");
      send_byte(8'hFF);
      send_byte(8'h80);
      send_byte(8'h7F);
      send_byte(CHAR_NEWLINE);

      // keyword ending on the last scanned byte, then one byte too late
      repeat (SCAN_LIMIT - 5) send_byte("a");
      send_text("debug\n");
      repeat (SCAN_LIMIT - 4) send_byte("a");
      send_text("debug\n");

      // receiver holds off while short lines keep coming
      steady = 1'b1;
      hold_now <= 1'b1;
      repeat (10) send_random_line();
      steady = 1'b0;

      // random lines up to the overall byte budget
      while (bytes_sent < TOTAL_BYTES) send_random_line();

      // trailing partial line, never reported
      send_text("Error");
      req_bus.valid <= 1'b0;

      do @(posedge clock); while (results_due != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_total == 0) begin
         $display("log_line_severity_classifier_unit test passed");
      end else begin
         $display("log_line_severity_classifier_unit test failed");
      end
      $finish;
   end

   // result side: stretches of full speed, random stalls, one long hold-off
   initial begin
      int  stall_mode;
      int  mode_left;
      int  stall_left;
      bit  held_done;
      stall_mode = 0;
      mode_left  = 0;
      stall_left = 0;
      held_done  = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_now && !held_done) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            held_done = 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 2);
               mode_left  = $urandom_range(20, 120);
            end
            mode_left = mode_left - 1;
            if (stall_left > 0) begin
               stall_left = stall_left - 1;
               rsp_bus.ready <= 1'b0;
            end else if (stall_mode != 0 && $urandom_range(0, 99) < 25) begin
               stall_left = idle_length() - 1;
               rsp_bus.ready <= 1'b0;
            end else begin
               rsp_bus.ready <= 1'b1;
            end
         end
      end
   end

   // watchdog on cycles with no request and no result taken
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles = quiet_cycles + 1;
         end
      end
      $display("%0t: no traffic for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("log_line_severity_classifier_unit test failed");
      $finish;
   end

endmodule

// ===== files.f =====
src/lsc_pkg.sv
src/lsc_req_if.sv
src/lsc_rsp_if.sv
src/lsc_keyword_match.sv
src/log_line_severity_classifier_unit.sv
src/lsc_checker.sv
dv/line_severity_monitor.sv
dv/tb.sv
